// ===== sv/scf_pkg.sv =====
// ----------------------------------------------------------------------------
// Searchable circular FIFO package
// Request and response layouts, the stored record and command and status codes.
// ----------------------------------------------------------------------------
package scf_pkg;

    localparam int DEPTH_DEFAULT = 16;

    // Command codes carried in the cmd field of a request.
    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    // Status codes carried in a response.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] user_key;
        logic [15:0] client_key;
        logic        logged_flag;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] popped_user;
        logic [15:0] popped_client;
        logic        popped_logged;
        logic        user_hit;
        logic [3:0]  hit_slot;
        logic        logged_hit;
        logic        client_hit;
        logic [4:0]  fill_count;
    } t_rsp;

    typedef struct packed {
        logic [31:0] user;
        logic [15:0] client;
        logic        logged;
    } t_entry;

    typedef struct packed {
        logic user_hit;
        logic logged_hit;
        logic client_hit;
    } t_hit_flags;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SCAN
    } t_state;

endpackage

// ===== sv/scf_scan.sv =====
// ----------------------------------------------------------------------------
// Lookup compare unit
// Compares one stored record per cycle, while enabled, with the search keys
// and accumulates the hit flags and the slot of the first user match.
// ----------------------------------------------------------------------------
module scf_scan #(
    parameter int PW = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_clear,
    input  logic                i_en,
    input  scf_pkg::t_entry     i_entry,
    input  logic [PW-1:0]       i_slot,
    input  logic [31:0]         i_user_key,
    input  logic [15:0]         i_client_key,
    output scf_pkg::t_hit_flags o_flags,
    output logic [PW-1:0]       o_slot
);
    import scf_pkg::*;

    t_hit_flags    r_flags, n_flags;
    logic [PW-1:0] r_slot, n_slot;
    logic          user_match;

    // The outputs include the record under compare in this cycle.
    always_comb begin
        user_match         = (i_entry.user == i_user_key);
        n_flags            = r_flags;
        n_slot             = r_slot;
        if (user_match && !r_flags.user_hit) begin
            n_flags.user_hit = 1'b1;
            n_slot           = i_slot;
        end
        if (user_match && i_entry.logged) begin
            n_flags.logged_hit = 1'b1;
        end
        if (i_entry.client == i_client_key) begin
            n_flags.client_hit = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_flags <= '0;
            r_slot  <= '0;
        end else if (i_en) begin
            r_flags <= n_flags;
            r_slot  <= n_slot;
        end
    end

    assign o_flags = n_flags;
    assign o_slot  = n_slot;

endmodule

// ===== sv/searchable_circular_fifo_core.sv =====
// ----------------------------------------------------------------------------
// Searchable circular FIFO core
// A circular queue of user records with push, pop and a key lookup.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its response appears
// on o_rsp for exactly one cycle, marked by o_done, and must be captured then
// because the block cannot be held off. A push, a refused pop, a lookup on an
// empty queue and an unused command answer in the cycle after the request. A
// pop takes the oldest record from the registered read of the record store in
// S_POP and answers from it. A lookup scans in S_SCAN, where the record
// store has a single read port and one compare unit checks one stored
// record per cycle, oldest first. Busy is high while a pop or lookup runs.
// A push on a full queue or a pop on an empty queue reports its status and
// changes nothing. When a pop empties the queue both pointers go back to slot
// zero. The record store is not cleared at reset; only occupied slots are used.
// ----------------------------------------------------------------------------
module searchable_circular_fifo_core #(
    parameter int DEPTH = scf_pkg::DEPTH_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  scf_pkg::t_req i_req,
    output logic          o_done,
    output scf_pkg::t_rsp o_rsp
);
    import scf_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] OCC_FULL = CW'(DEPTH);
    localparam logic [CW-1:0] OCC_ONE  = CW'(1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

    // Control state.
    t_state        r_state, n_state;
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_occ, n_occ;
    logic [PW-1:0] r_scan_ptr, n_scan_ptr;
    logic [CW-1:0] r_remain, n_remain;
    logic          r_done, n_done;

    // Request and response holding registers.
    t_req          r_req, n_req;
    t_rsp          r_rsp, n_rsp;

    // Record store with a single registered read port.
    t_entry        r_mem [DEPTH];
    t_entry        r_rd_data;
    logic [PW-1:0] r_rd_slot;
    logic [PW-1:0] rd_addr;
    logic          mem_we;
    t_entry        wr_entry;

    // Compare unit hookup.
    logic          scan_clear;
    logic          scan_en;
    t_hit_flags    scan_flags;
    logic [PW-1:0] scan_slot;

    function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + PW'(1);
    endfunction

    assign wr_entry = '{user: i_req.user_key, client: i_req.client_key,
                        logged: i_req.logged_flag};

    always_comb begin
        n_state    = r_state;
        n_wr_ptr   = r_wr_ptr;
        n_rd_ptr   = r_rd_ptr;
        n_occ      = r_occ;
        n_scan_ptr = r_scan_ptr;
        n_remain   = r_remain;
        n_req      = r_req;
        n_rsp      = r_rsp;
        n_done     = 1'b0;
        mem_we     = 1'b0;
        rd_addr    = r_rd_ptr;
        scan_clear = 1'b0;
        scan_en    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req = i_req;
                    n_rsp = '0;
                    n_rsp.fill_count = 5'(r_occ);
                    case (i_req.cmd)
                        CMD_PUSH: begin
                            n_done = 1'b1;
                            if (r_occ == OCC_FULL) begin
                                n_rsp.status = ST_FULL;
                            end else begin
                                mem_we           = 1'b1;
                                n_wr_ptr         = next_slot(r_wr_ptr);
                                n_occ            = r_occ + OCC_ONE;
                                n_rsp.fill_count = 5'(n_occ);
                            end
                        end
                        CMD_POP: begin
                            if (r_occ == '0) begin
                                n_done       = 1'b1;
                                n_rsp.status = ST_EMPTY;
                            end else begin
                                // The oldest record is read at this edge.
                                n_state = S_POP;
                            end
                        end
                        CMD_LOOKUP: begin
                            if (r_occ == '0) begin
                                n_done = 1'b1;
                            end else begin
                                // The oldest record is read at this edge; the
                                // scan pointer already looks one slot ahead.
                                scan_clear = 1'b1;
                                n_scan_ptr = next_slot(r_rd_ptr);
                                n_remain   = r_occ;
                                n_state    = S_SCAN;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_POP: begin
                n_done              = 1'b1;
                n_occ               = r_occ - OCC_ONE;
                n_rsp.popped_user   = r_rd_data.user;
                n_rsp.popped_client = r_rd_data.client;
                n_rsp.popped_logged = r_rd_data.logged;
                n_rsp.fill_count    = 5'(n_occ);
                if (r_occ == OCC_ONE) begin
                    n_rd_ptr = '0;
                    n_wr_ptr = '0;
                end else begin
                    n_rd_ptr = next_slot(r_rd_ptr);
                end
                n_state = S_IDLE;
            end
            S_SCAN: begin
                // One stored record is compared per cycle while the next one
                // is being read.
                scan_en    = 1'b1;
                rd_addr    = r_scan_ptr;
                n_scan_ptr = next_slot(r_scan_ptr);
                n_remain   = r_remain - OCC_ONE;
                if (r_remain == OCC_ONE) begin
                    n_done           = 1'b1;
                    n_rsp.user_hit   = scan_flags.user_hit;
                    n_rsp.hit_slot   = 4'(scan_slot);
                    n_rsp.logged_hit = scan_flags.logged_hit;
                    n_rsp.client_hit = scan_flags.client_hit;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_occ      <= '0;
            r_scan_ptr <= '0;
            r_remain   <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_wr_ptr   <= n_wr_ptr;
            r_rd_ptr   <= n_rd_ptr;
            r_occ      <= n_occ;
            r_scan_ptr <= n_scan_ptr;
            r_remain   <= n_remain;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_rsp <= n_rsp;
    end

    // The store is written only by an accepted push and read every cycle at
    // the address chosen above; the slot tag follows the read data.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wr_ptr] <= wr_entry;
        end
        r_rd_data <= r_mem[rd_addr];
        r_rd_slot <= rd_addr;
    end

    scf_scan #(
        .PW(PW)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (scan_clear),
        .i_en         (scan_en),
        .i_entry      (r_rd_data),
        .i_slot       (r_rd_slot),
        .i_user_key   (r_req.user_key),
        .i_client_key (r_req.client_key),
        .o_flags      (scan_flags),
        .o_slot       (scan_slot)
    );

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

// ===== sv/scf_checker.sv =====
// ----------------------------------------------------------------------------
// Searchable circular FIFO checker
// Port level checks of the response timing and of status consistency.
// ----------------------------------------------------------------------------
module scf_checker #(
    parameter int DEPTH = scf_pkg::DEPTH_DEFAULT
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input scf_pkg::t_req i_req,
    input logic          o_done,
    input scf_pkg::t_rsp o_rsp
);
    import scf_pkg::*;

    // A push always answers in the following cycle.
    a_push_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.cmd == CMD_PUSH) |=> o_done)
        else $error("push request did not answer in the next cycle");

    // A response is only given once the sequencer has returned to idle.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("response while a request is still running");

    // A refused push reports a full queue.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status == ST_FULL) |-> (o_rsp.fill_count == 5'(DEPTH)))
        else $error("full status with a count other than the depth");

    // A refused pop reports an empty queue and no record.
    a_empty_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status == ST_EMPTY) |->
            (o_rsp.fill_count == '0 && o_rsp.popped_user == '0 &&
             o_rsp.popped_client == '0 && !o_rsp.popped_logged))
        else $error("empty status with a record or a nonzero count");

    // Reset leaves the block idle with no response pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_done && !busy))
        else $error("block not idle after reset");

endmodule

bind searchable_circular_fifo_core scf_checker #(.DEPTH(DEPTH)) u_scf_checker (.*);

// ===== verif/tb_searchable_circular_fifo_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Searchable circular FIFO core testbench
// Drives push, pop and lookup requests with random idle gaps. A scoreboard
// keeps its own copy of the record queue, predicts every response and checks
// each response field against the oldest prediction.
// ----------------------------------------------------------------------------

// Shadow copy of the record queue. Each accepted request updates it and leaves
// the response it should produce. Each observed response is checked against the
// oldest such prediction.
class fifo_record_checker;

    logic [31:0]   shadow_user   [scf_pkg::DEPTH_DEFAULT];
    logic [15:0]   shadow_client [scf_pkg::DEPTH_DEFAULT];
    logic          shadow_logged [scf_pkg::DEPTH_DEFAULT];
    int unsigned   wr_slot   = 0;
    int unsigned   rd_slot   = 0;
    int unsigned   occupied  = 0;
    scf_pkg::t_rsp pending_rsp[$];
    int            n_fail    = 0;

    function automatic string describe(scf_pkg::t_rsp r);
        return $sformatf({"status=%0d pop=%h/%h/%b hit=%b slot=%0d logged_hit=%b ",
                          "client_hit=%b fill=%0d"},
                         r.status, r.popped_user, r.popped_client, r.popped_logged,
                         r.user_hit, r.hit_slot, r.logged_hit, r.client_hit,
                         r.fill_count);
    endfunction

    function automatic void note_request(scf_pkg::t_req req);
        scf_pkg::t_rsp rsp;
        int unsigned   p;
        bit            found;
        rsp   = '0;
        found = 1'b0;
        case (req.cmd)
            scf_pkg::CMD_PUSH: begin
                if (occupied >= scf_pkg::DEPTH_DEFAULT) begin
                    rsp.status = scf_pkg::ST_FULL;
                end else begin
                    shadow_user[wr_slot]   = req.user_key;
                    shadow_client[wr_slot] = req.client_key;
                    shadow_logged[wr_slot] = req.logged_flag;
                    wr_slot  = (wr_slot + 1) % scf_pkg::DEPTH_DEFAULT;
                    occupied = occupied + 1;
                end
            end
            scf_pkg::CMD_POP: begin
                if (occupied == 0) begin
                    rsp.status = scf_pkg::ST_EMPTY;
                end else begin
                    rsp.popped_user   = shadow_user[rd_slot];
                    rsp.popped_client = shadow_client[rd_slot];
                    rsp.popped_logged = shadow_logged[rd_slot];
                    occupied = occupied - 1;
                    // Draining the queue sends both pointers back to slot zero.
                    if (occupied == 0) begin
                        rd_slot = 0;
                        wr_slot = 0;
                    end else begin
                        rd_slot = (rd_slot + 1) % scf_pkg::DEPTH_DEFAULT;
                    end
                end
            end
            scf_pkg::CMD_LOOKUP: begin
                p = rd_slot;
                for (int n = 0; n < occupied; n++) begin
                    if (shadow_user[p] == req.user_key) begin
                        if (!found) begin
                            found        = 1'b1;
                            rsp.hit_slot = p[3:0];
                        end
                        if (shadow_logged[p]) begin
                            rsp.logged_hit = 1'b1;
                        end
                    end
                    if (shadow_client[p] == req.client_key) begin
                        rsp.client_hit = 1'b1;
                    end
                    p = (p + 1) % scf_pkg::DEPTH_DEFAULT;
                end
                rsp.user_hit = found;
            end
            default: begin
            end
        endcase
        rsp.fill_count = occupied[4:0];
        pending_rsp.push_back(rsp);
    endfunction

    function automatic void check_response(scf_pkg::t_rsp got);
        scf_pkg::t_rsp want;
        if (pending_rsp.size() == 0) begin
            n_fail++;
            if (n_fail <= 10) begin
                $display("ERROR: response with no request outstanding: %s", describe(got));
            end
            return;
        end
        want = pending_rsp.pop_front();
        if (got.status !== want.status || got.popped_user !== want.popped_user ||
            got.popped_client !== want.popped_client ||
            got.popped_logged !== want.popped_logged || got.user_hit !== want.user_hit ||
            got.hit_slot !== want.hit_slot || got.logged_hit !== want.logged_hit ||
            got.client_hit !== want.client_hit || got.fill_count !== want.fill_count) begin
            n_fail++;
            if (n_fail <= 10) begin
                $display("ERROR: response mismatch at %0t", $realtime);
                $display("  expected %s", describe(want));
                $display("  actual   %s", describe(got));
            end
        end
    endfunction

endclass

module tb_searchable_circular_fifo_core;

    import scf_pkg::*;

    // Command code 3 has no meaning; the block answers it and changes nothing.
    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS = 500;
    // The slowest correct run is about 530 requests, each a full lookup plus an
    // idle gap; this limit is many times that.
    localparam int         CYCLE_LIMIT  = 200_000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic busy;
    t_req i_req   = '0;
    logic o_done;
    t_rsp o_rsp;

    fifo_record_checker checker_q = new;

    // During the calm stretch the sender never pauses between requests.
    bit          calm = 1'b0;
    int unsigned cycle_count = 0;
    logic [31:0] user_pool   [8];
    logic [15:0] client_pool [8];

    searchable_circular_fifo_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost response ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Everything here samples the values from before the edge. A response is
    // checked before a request taken at the same edge is noted, because that
    // response always belongs to an earlier request.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                checker_q.check_response(o_rsp);
            end
            if (start && !busy) begin
                checker_q.note_request(i_req);
            end
        end
    end

    // Drops start for a random number of cycles, roughly 26 in a hundred.
    // The gap begins right after an acceptance, so it falls on any cycle of a
    // pop or lookup that is still running.
    task automatic idle_gap();
        int n = 0;
        if (!calm) begin
            while ($urandom_range(0, 99) < 26) begin
                n++;
            end
        end
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Presents one request and returns at the edge that accepts it. Start
    // stays high, so a following request goes out without a dip.
    task automatic send(input logic [1:0] cmd, input logic [31:0] user,
                        input logic [15:0] client, input logic logged);
        t_req req;
        req.cmd         = cmd;
        req.user_key    = user;
        req.client_key  = client;
        req.logged_flag = logged;
        idle_gap();
        start <= 1'b1;
        i_req <= req;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
    endtask

    // Keys mostly come from a small pool, so that lookups hit and the same
    // user sits in several slots with different logged-in flags.
    function automatic logic [31:0] pick_user();
        return ($urandom_range(0, 99) < 70) ? user_pool[$urandom_range(0, 7)] : $urandom;
    endfunction

    function automatic logic [15:0] pick_client();
        logic [31:0] raw;
        raw = $urandom;
        return ($urandom_range(0, 99) < 70) ? client_pool[$urandom_range(0, 7)] : raw[15:0];
    endfunction

    initial begin
        int          accepted;
        int          push_pct;
        int          sel;
        logic [1:0]  cmd;

        for (int i = 0; i < 8; i++) begin
            user_pool[i]   = $urandom;
            client_pool[i] = 16'($urandom_range(0, 65535));
        end
        user_pool[0]   = 32'h0000_0000;
        user_pool[1]   = 32'hFFFF_FFFF;
        client_pool[0] = 16'h0000;
        client_pool[1] = 16'hFFFF;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. An empty queue answers a lookup with no hits, refuses
        // a pop and ignores the unused command.
        send(CMD_LOOKUP, 32'h0000_0000, 16'h0000, 1'b0);
        send(CMD_POP,    32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        send(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        // Field extremes go in and come back out; the second pop drains the
        // queue, which returns the pointers to slot zero.
        send(CMD_PUSH,   32'h0000_0000, 16'h0000, 1'b0);
        send(CMD_PUSH,   32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        send(CMD_LOOKUP, 32'hFFFF_FFFF, 16'h0000, 1'b0);
        send(CMD_LOOKUP, 32'h0000_0000, 16'hFFFF, 1'b1);
        send(CMD_POP,    32'h0000_0000, 16'h0000, 1'b0);
        send(CMD_POP,    32'h0000_0000, 16'h0000, 1'b0);
        send(CMD_POP,    32'h0000_0000, 16'h0000, 1'b0);
        // Fill the queue with repeated user ids and alternating flags, then
        // push once more to see the full refusal. A lookup of a full queue
        // must reach the newest slot.
        for (int i = 0; i < DEPTH_DEFAULT; i++) begin
            send(CMD_PUSH, 32'h1000_0000 | (i % 5), 16'(16'h0100 + i), i[0]);
        end
        send(CMD_PUSH,   32'hDEAD_0000, 16'h5555, 1'b1);
        send(CMD_LOOKUP, 32'h1000_0003, 16'h010F, 1'b0);
        send(CMD_LOOKUP, 32'h2000_0000, 16'hAAAA, 1'b0);

        // Random part. The push share swings between high and low every 48
        // requests, so the queue keeps running full, draining and wrapping.
        // The unused command is noise and does not count.
        accepted = 0;
        while (accepted < RANDOM_ITEMS) begin
            push_pct = ((accepted / 48) % 2 == 0) ? 75 : 25;
            calm     = (accepted >= 200 && accepted < 300);
            sel      = $urandom_range(0, 99);
            if (sel < 4) begin
                cmd = CMD_UNUSED;
            end else if (sel < 34) begin
                cmd = CMD_LOOKUP;
            end else if ($urandom_range(0, 99) < push_pct) begin
                cmd = CMD_PUSH;
            end else begin
                cmd = CMD_POP;
            end
            send(cmd, pick_user(), pick_client(), 1'($urandom_range(0, 1)));
            if (cmd != CMD_UNUSED) begin
                accepted++;
            end
        end
        start <= 1'b0;

        // Let the last responses arrive, then give the block a full lookup's
        // worth of cycles to show any response that should not be there.
        while (checker_q.pending_rsp.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DEPTH_DEFAULT + 4) @(posedge i_clk);

        if (checker_q.n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
